/* rtl/cfwh_pkg.sv */
`default_nettype none

package cfwh_pkg;

  // width of the bin index seen on the ports
  localparam int IDX_OUT_W = 6;

  // item kinds
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // clamp codes of a result
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DOMAIN_START = 2'd0,
    REG_BIN_WIDTH    = 2'd1,
    REG_BIN_COUNT    = 2'd2
  } cfg_reg_t;

  // front states
  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  // back states
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t                  op;
    clamp_t               code;
    logic                 no_store;
    logic [IDX_OUT_W-1:0] idx;
  } entry_ctrl_t;

endpackage

`default_nettype wire

/* rtl/cfwh_front.sv */
`default_nettype none

module cfwh_front import cfwh_pkg::*; #(
  parameter int MAX_BINS = 64,
  parameter int BIN_W    = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic                 in_mode,
  input  wire logic [31:0]          in_sample,
  input  wire logic [IDX_OUT_W-1:0] in_read_bin,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data,
  output logic                      busy,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output entry_ctrl_t               push_ctrl,
  output logic [BIN_W-1:0]          push_bin
);

  front_state_t state_r, state_nxt;

  logic [31:0] start_r;
  logic [31:0] width_r;
  logic [6:0]  count_r;

  op_t                  op_r;
  logic                 low_r;
  logic [IDX_OUT_W-1:0] rbin_r;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          dvd_r, dvd_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [4:0]           step_r;

  logic [32:0] trial;
  logic [32:0] trial_diff;
  logic        trial_ge;
  logic [31:0] n_ext;
  logic [31:0] cnt_ext;
  logic [31:0] bin_ext;
  logic [31:0] rbin_ext;
  clamp_t      code_sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 32'd0;
      width_r <= 32'd1;
      count_r <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOMAIN_START: start_r <= cfg_data;
        REG_BIN_WIDTH:    width_r <= cfg_data;
        REG_BIN_COUNT:    count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // one restoring division step
  assign trial      = {rem_r, dvd_r[31]};
  assign trial_diff = trial - {1'b0, width_r};
  assign trial_ge   = trial >= {1'b0, width_r};

  always_comb begin
    rem_nxt = trial_ge ? trial_diff[31:0] : trial[31:0];
    dvd_nxt = {dvd_r[30:0], 1'b0};
    quo_nxt = {quo_r[30:0], trial_ge};
  end

  // bins in use, bounded to one and to storage
  assign cnt_ext = {25'd0, count_r};
  always_comb begin
    if (cnt_ext == 32'd0) begin
      n_ext = 32'd1;
    end else if (cnt_ext > 32'(MAX_BINS)) begin
      n_ext = 32'(MAX_BINS);
    end else begin
      n_ext = cnt_ext;
    end
  end

  // final bin choice and clamp
  assign rbin_ext = {{(32-IDX_OUT_W){1'b0}}, rbin_r};
  always_comb begin
    if (op_r == OP_READ) begin
      bin_ext  = rbin_ext;
      code_sel = CLAMP_NONE;
    end else if (low_r) begin
      bin_ext  = 32'd0;
      code_sel = CLAMP_LOW;
    end else if (quo_r >= n_ext) begin
      bin_ext  = n_ext - 32'd1;
      code_sel = CLAMP_HIGH;
    end else begin
      bin_ext  = quo_r;
      code_sel = CLAMP_NONE;
    end
  end

  assign push_bin           = bin_ext[BIN_W-1:0];
  assign push_ctrl.op       = op_r;
  assign push_ctrl.code     = code_sel;
  assign push_ctrl.no_store = (op_r == OP_READ) && (rbin_ext >= 32'(MAX_BINS));
  assign push_ctrl.idx      = bin_ext[IDX_OUT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (take) begin
          if ((in_mode == OP_READ) || (in_sample < start_r) || (width_r == 32'd0)) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (step_r == 5'd31) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy       = 1'b1;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE:  busy = 1'b0;
      F_DIV:   ;
      F_PUSH:  push_valid = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item and divider registers
  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= op_t'(in_mode);
      rbin_r <= in_read_bin;
      low_r  <= in_sample < start_r;
      dvd_r  <= in_sample - start_r;
      rem_r  <= 32'd0;
      quo_r  <= '1;
      step_r <= 5'd0;
    end else if (state_r == F_DIV) begin
      rem_r  <= rem_nxt;
      dvd_r  <= dvd_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + 5'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/cfwh_queue.sv */
`default_nettype none

module cfwh_queue import cfwh_pkg::*; #(
  parameter int BIN_W = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire entry_ctrl_t push_ctrl,
  input  wire logic [BIN_W-1:0] push_bin,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output entry_ctrl_t      pop_ctrl,
  output logic [BIN_W-1:0] pop_bin
);

  // two-entry queue
  entry_ctrl_t      ctrl_q [2];
  logic [BIN_W-1:0] bin_q  [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_ready && pop_valid;
  assign pop_ctrl   = ctrl_q[rd_ptr_r];
  assign pop_bin    = bin_q[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ctrl_q[wr_ptr_r] <= push_ctrl;
      bin_q[wr_ptr_r]  <= push_bin;
    end
  end

endmodule

`default_nettype wire

/* rtl/cfwh_back.sv */
`default_nettype none

module cfwh_back import cfwh_pkg::*; #(
  parameter int MAX_BINS    = 64,
  parameter int COUNT_WIDTH = 32,
  parameter int BIN_W       = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  input  wire entry_ctrl_t          pop_ctrl,
  input  wire logic [BIN_W-1:0]     pop_bin,
  output logic                      clearing,
  output logic                      out_valid,
  output logic [IDX_OUT_W-1:0]      out_bin_index,
  output logic [31:0]               out_bin_total,
  output logic [1:0]                out_clamp_code
);

  back_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [BIN_W-1:0]       clr_addr_r;
  entry_ctrl_t            ctrl_r;
  logic [BIN_W-1:0]       bin_r;

  logic                   out_valid_r;
  logic [IDX_OUT_W-1:0]   out_idx_r;
  logic [31:0]            out_total_r;
  clamp_t                 out_code_r;

  logic                   mem_re;
  logic                   mem_we;
  logic                   result_load;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic [COUNT_WIDTH-1:0] total_val;
  logic [63:0]            total_ext;
  logic                   clr_last;

  assign clr_last = clr_addr_r == BIN_W'(MAX_BINS - 1);

  // saturating increment and result value
  assign inc_val   = (rd_data_r == '1) ? rd_data_r : rd_data_r + 1'b1;
  always_comb begin
    if (ctrl_r.op == OP_ADD) begin
      total_val = inc_val;
    end else if (ctrl_r.no_store) begin
      total_val = '0;
    end else begin
      total_val = rd_data_r;
    end
  end
  assign total_ext = 64'(total_val);

  assign wr_addr = (state_r == B_CLEAR) ? clr_addr_r : bin_r;
  assign wr_data = (state_r == B_CLEAR) ? '0 : inc_val;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: begin
        if (clr_last) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC:  state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    pop_ready   = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    result_load = 1'b0;
    clearing    = 1'b0;
    case (state_r)
      B_CLEAR: begin
        mem_we   = 1'b1;
        clearing = 1'b1;
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        mem_re    = pop_valid;
      end
      B_EXEC: begin
        mem_we      = ctrl_r.op == OP_ADD;
        result_load = 1'b1;
      end
      default: clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= result_load;
      if (state_r == B_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[pop_bin];
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (mem_re) begin
      ctrl_r <= pop_ctrl;
      bin_r  <= pop_bin;
    end
    if (result_load) begin
      out_idx_r   <= ctrl_r.idx;
      out_total_r <= total_ext[31:0];
      out_code_r  <= ctrl_r.code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_index  = out_idx_r;
  assign out_bin_total  = out_total_r;
  assign out_clamp_code = out_code_r;

endmodule

`default_nettype wire

/* rtl/clamped_fixed_width_histogram.sv */
// channel   handshake              payload
// input     start, busy            in_mode, in_sample, in_read_bin
// result    out_valid (strobe)     out_bin_index, out_bin_total, out_clamp_code
// config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// an add item holds the front for acceptance, 32 divider steps and the hand-off;
// a read item or a clamped-low or zero-width add skips the divider steps
// the back reads the counter memory for each item and, for an add, writes back the
// increment; the result strobe is registered; a two-entry queue sits between
// after reset a clearing pass zeroes each of the MAX_BINS counters, busy is high
// the receiver cannot stall; config writes are always taken

`default_nettype none

module clamped_fixed_width_histogram import cfwh_pkg::*; #(
  parameter int MAX_BINS    = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_mode,
  input  wire logic [31:0]          in_sample,
  input  wire logic [IDX_OUT_W-1:0] in_read_bin,
  output logic                      out_valid,
  output logic [IDX_OUT_W-1:0]      out_bin_index,
  output logic [31:0]               out_bin_total,
  output logic [1:0]                out_clamp_code,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic             front_busy;
  logic             take;
  logic             clearing;
  logic             push_valid;
  logic             push_ready;
  entry_ctrl_t      push_ctrl;
  logic [BIN_W-1:0] push_bin;
  logic             pop_valid;
  logic             pop_ready;
  entry_ctrl_t      pop_ctrl;
  logic [BIN_W-1:0] pop_bin;

  // item acceptance
  assign busy      = front_busy | clearing;
  assign take      = start & ~busy;
  assign cfg_ready = 1'b1;

  cfwh_front #(
    .MAX_BINS (MAX_BINS),
    .BIN_W    (BIN_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .in_mode     (in_mode),
    .in_sample   (in_sample),
    .in_read_bin (in_read_bin),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .busy        (front_busy),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_ctrl   (push_ctrl),
    .push_bin    (push_bin)
  );

  cfwh_queue #(
    .BIN_W (BIN_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctrl  (push_ctrl),
    .push_bin   (push_bin),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctrl   (pop_ctrl),
    .pop_bin    (pop_bin)
  );

  cfwh_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .BIN_W       (BIN_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_ctrl       (pop_ctrl),
    .pop_bin        (pop_bin),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_bin_index  (out_bin_index),
    .out_bin_total  (out_bin_total),
    .out_clamp_code (out_clamp_code)
  );

endmodule

`default_nettype wire
